// ===== sv/exact_color_slot_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Exact color slot allocator assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EXACT_COLOR_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define EXACT_COLOR_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ecsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Exact color slot allocator package
// Types, constants and small palette functions shared by the allocator.
// ----------------------------------------------------------------------------
package ecsa_pkg;

  localparam int unsigned DEF_SLOT_COUNT = 16;

  localparam int unsigned RGB_W = 24;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CH_W  = 10;
  localparam int unsigned TC_W  = 15;

  localparam int unsigned MAC_A_W = 18;
  localparam int unsigned MAC_B_W = 19;
  localparam int unsigned ACC_W   = MAC_A_W + MAC_B_W;

  localparam int unsigned SCALE_MUL   = 1000;
  localparam int unsigned SCALE_BIAS  = 254;
  localparam int unsigned SCALE_RECIP = 263173;
  localparam int unsigned SCALE_SHIFT = 26;
  localparam int unsigned CH_FULL     = 1000;

  localparam int unsigned W_RED      = 299;
  localparam int unsigned W_GREEN    = 587;
  localparam int unsigned W_BLUE     = 114;
  localparam int unsigned GREY_RECIP = 268436;
  localparam int unsigned GREY_SHIFT = 28;
  localparam int unsigned DIV10_MUL   = 205;
  localparam int unsigned DIV10_SHIFT = 11;

  localparam int unsigned GREY_BASE     = 8;
  localparam int unsigned GREY_STEP     = 10;
  localparam int unsigned GREY_STEP_MAX = 23;
  localparam int unsigned GREY_FIRST    = 232;
  localparam int unsigned CUBE_FIRST    = 16;
  localparam int unsigned CUBE_SIDE     = 6;
  localparam int unsigned CAND_MIN      = 16;
  localparam int unsigned CAND_MAX      = 255;
  localparam int unsigned PALETTE_FULL  = 256;

  localparam logic REQ_MAP     = 1'b0;
  localparam logic REQ_RESTORE = 1'b1;

  localparam logic CFG_EXACT_ENABLE    = 1'b0;
  localparam logic CFG_TERMINAL_COLORS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_QUANT,
    ST_SCALE,
    ST_RST_RD,
    ST_RST_LD
  } state_t;

  typedef enum logic [3:0] {
    Q_CUBE_R,
    Q_CUBE_G,
    Q_CUBE_B,
    Q_LUMA_R,
    Q_LUMA_G,
    Q_LUMA_B,
    Q_LUMA_DIV,
    Q_STEP_DIV,
    Q_STEP_TAKE,
    Q_GREY_R,
    Q_GREY_G,
    Q_GREY_B,
    Q_PICK
  } qstep_t;

  typedef enum logic [1:0] {
    SP_MUL,
    SP_RECIP,
    SP_TAKE
  } sphase_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef struct packed {
    logic               accum;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [MAC_B_W-1:0] addend;
  } mac_op_t;

  typedef struct packed {
    logic [RGB_W-1:0] color;
    logic [IDX_W-1:0] index;
  } slot_entry_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [2:0] cube_idx(input logic [7:0] v);
    logic [2:0] r;
    if (v <= 8'd47) begin
      r = 3'd0;
    end else if (v <= 8'd115) begin
      r = 3'd1;
    end else if (v <= 8'd155) begin
      r = 3'd2;
    end else if (v <= 8'd195) begin
      r = 3'd3;
    end else if (v <= 8'd235) begin
      r = 3'd4;
    end else begin
      r = 3'd5;
    end
    return r;
  endfunction

  function automatic logic [7:0] cube_lv(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'd0;
      3'd1: r = 8'd95;
      3'd2: r = 8'd135;
      3'd3: r = 8'd175;
      3'd4: r = 8'd215;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cube_code(input logic [2:0] cr, input logic [2:0] cg,
                                           input logic [2:0] cb);
    return 8'(CUBE_FIRST) + 8'(cr) * 8'(CUBE_SIDE * CUBE_SIDE)
         + 8'(cg) * 8'(CUBE_SIDE) + 8'(cb);
  endfunction

  function automatic logic [7:0] grey_level(input logic [4:0] gi);
    return 8'(GREY_BASE) + 8'(gi) * 8'(GREY_STEP);
  endfunction

  function automatic logic [RGB_W-1:0] canon_rgb(input logic [7:0] idx);
    logic [RGB_W-1:0] r;
    logic [7:0]       v;
    r = '0;
    v = '0;
    if (idx >= 8'(GREY_FIRST)) begin
      v = grey_level(5'(idx - 8'(GREY_FIRST)));
      r = {v, v, v};
    end else begin
      for (int ir = 0; ir < int'(CUBE_SIDE); ir++) begin
        for (int ig = 0; ig < int'(CUBE_SIDE); ig++) begin
          for (int ib = 0; ib < int'(CUBE_SIDE); ib++) begin
            if (idx == cube_code(3'(ir), 3'(ig), 3'(ib))) begin
              r = {cube_lv(3'(ir)), cube_lv(3'(ig)), cube_lv(3'(ib))};
            end
          end
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/exact_color_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Exact color slot allocator
// Maps 24-bit colors to palette indices by exact slots or xterm-256 snapping.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy stays high
// until the request's last result word has been issued. Each result word is on
// the out_ ports for exactly one cycle with out_valid high and must be taken
// then. Distances, luma, divisions and channel scaling all run through one
// shared multiply-accumulate unit, one product per cycle, and the slot memory
// has a registered read. A map request returns the basic color, finds an exact
// hit in a scan of the allocated slots, allocates a slot or snaps to the
// palette; the scan runs only in exact mode. A restore request issues one
// result word per allocated slot, or a single word with none.
module exact_color_slot_allocator_unit
  import ecsa_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [TC_W-1:0]  cfg_data,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [RGB_W-1:0] in_rgb_color,
  input  logic [2:0]       in_basic_color,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_color_index,
  output logic             out_write_valid,
  output logic [IDX_W-1:0] out_write_slot,
  output logic [CH_W-1:0]  out_write_red,
  output logic [CH_W-1:0]  out_write_green,
  output logic [CH_W-1:0]  out_write_blue,
  output logic             out_last
);

`include "exact_color_slot_allocator_unit_defines.svh"

  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  state_t           state_r, state_nxt;
  qstep_t           qstep_r, qstep_nxt;
  sphase_t          sph_r, sph_nxt;
  chan_t            ch_r, ch_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             req_r, req_nxt;
  logic             exact_r, exact_nxt;
  logic [TC_W-1:0]  tc_r, tc_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [RGB_W-1:0] rgb_r, rgb_nxt;
  logic [2:0]       basic_r, basic_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [12:0]      cd_r, cd_nxt;
  logic [4:0]       gi_r, gi_nxt;
  logic [CH_W-1:0]  red_r, red_nxt;
  logic [CH_W-1:0]  green_r, green_nxt;

  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  logic             out_wv_r, out_wv_nxt;
  logic [IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [CH_W-1:0]  out_red_r, out_red_nxt;
  logic [CH_W-1:0]  out_green_r, out_green_nxt;
  logic [CH_W-1:0]  out_blue_r, out_blue_nxt;
  logic             out_last_r, out_last_nxt;

  mac_op_t          mac_op;
  logic [ACC_W-1:0] acc;

  logic             mem_we;
  slot_entry_t      mem_wdata;
  slot_entry_t      mem_rdata;

  logic [7:0]       comp_r, comp_g, comp_b;
  logic [2:0]       ci_r, ci_g, ci_b;
  logic [7:0]       gv;
  logic [7:0]       ch_v;
  logic [7:0]       grey8;
  logic [7:0]       grey_x;
  logic [4:0]       gi_raw;
  logic [CH_W-1:0]  scaled;
  logic [15:0]      tc16, cnt16;
  logic [IDX_W-1:0] cand8;
  logic             cand_ok;
  logic [CW-1:0]    idx_inc;
  logic             idx_last;

  ecsa_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  ecsa_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    comp_r = rgb_r[23:16];
    comp_g = rgb_r[15:8];
    comp_b = rgb_r[7:0];
    ci_r   = cube_idx(comp_r);
    ci_g   = cube_idx(comp_g);
    ci_b   = cube_idx(comp_b);
    gv     = grey_level(gi_r);

    unique case (ch_r)
      CH_RED:   ch_v = comp_r;
      CH_GREEN: ch_v = comp_g;
      default:  ch_v = comp_b;
    endcase

    grey8  = acc[GREY_SHIFT +: 8];
    grey_x = (grey8 < 8'(GREY_BASE)) ? 8'd0 : (grey8 - 8'(GREY_BASE));
    gi_raw = acc[DIV10_SHIFT +: 5];
    scaled = (acc[SCALE_SHIFT +: CH_W] > CH_W'(CH_FULL)) ? CH_W'(CH_FULL)
                                                         : acc[SCALE_SHIFT +: CH_W];

    tc16    = 16'(tc_r);
    cnt16   = 16'(cnt_r);
    cand8   = 8'(tc16 - 16'd1 - cnt16);
    cand_ok = (tc16 > cnt16 + 16'(CAND_MIN)) && (tc16 <= cnt16 + 16'(CAND_MAX) + 16'd1);
    idx_inc  = CW'(idx_r + 1'b1);
    idx_last = (idx_inc == cnt_r);
  end

  always_comb begin
    state_nxt = state_r;
    qstep_nxt = qstep_r;
    sph_nxt   = sph_r;
    ch_nxt    = ch_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    req_nxt   = req_r;
    exact_nxt = exact_r;
    tc_nxt    = tc_r;
    rgb_nxt   = rgb_r;
    basic_nxt = basic_r;
    slot_nxt  = slot_r;
    cd_nxt    = cd_r;
    gi_nxt    = gi_r;
    red_nxt   = red_r;
    green_nxt = green_r;

    out_valid_nxt = 1'b0;
    out_index_nxt = '0;
    out_wv_nxt    = 1'b0;
    out_slot_nxt  = '0;
    out_red_nxt   = '0;
    out_green_nxt = '0;
    out_blue_nxt  = '0;
    out_last_nxt  = 1'b0;

    mac_op          = '0;
    mem_we          = 1'b0;
    mem_wdata.color = rgb_r;
    mem_wdata.index = cand8;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXACT_ENABLE:    exact_nxt = cfg_data[0];
        CFG_TERMINAL_COLORS: tc_nxt    = cfg_data;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          rgb_nxt   = in_rgb_color;
          basic_nxt = in_basic_color;
          idx_nxt   = '0;
          if (in_req_type == REQ_RESTORE) begin
            if (cnt_r == '0) begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
            end else begin
              state_nxt = ST_RST_RD;
            end
          end else if (exact_r && (cnt_r != '0)) begin
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (mem_rdata.color == rgb_r) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = mem_rdata.index;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (idx_last) begin
          state_nxt = ST_DECIDE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_DECIDE: begin
        if (!exact_r) begin
          if (tc_r >= TC_W'(PALETTE_FULL)) begin
            qstep_nxt = Q_CUBE_R;
            state_nxt = ST_QUANT;
          end else begin
            out_valid_nxt = 1'b1;
            out_index_nxt = IDX_W'(basic_r);
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if ((cnt_r == CW'(SLOT_COUNT)) || !cand_ok) begin
          qstep_nxt = Q_CUBE_R;
          state_nxt = ST_QUANT;
        end else begin
          mem_we    = 1'b1;
          cnt_nxt   = CW'(cnt_r + 1'b1);
          slot_nxt  = cand8;
          ch_nxt    = CH_RED;
          sph_nxt   = SP_MUL;
          state_nxt = ST_SCALE;
        end
      end

      ST_QUANT: begin
        unique case (qstep_r)
          Q_CUBE_R: begin
            mac_op.a  = MAC_A_W'(abs_diff(comp_r, cube_lv(ci_r)));
            mac_op.b  = MAC_B_W'(abs_diff(comp_r, cube_lv(ci_r)));
            qstep_nxt = Q_CUBE_G;
          end
          Q_CUBE_G: begin
            mac_op.accum = 1'b1;
            mac_op.a     = MAC_A_W'(abs_diff(comp_g, cube_lv(ci_g)));
            mac_op.b     = MAC_B_W'(abs_diff(comp_g, cube_lv(ci_g)));
            qstep_nxt    = Q_CUBE_B;
          end
          Q_CUBE_B: begin
            mac_op.accum = 1'b1;
            mac_op.a     = MAC_A_W'(abs_diff(comp_b, cube_lv(ci_b)));
            mac_op.b     = MAC_B_W'(abs_diff(comp_b, cube_lv(ci_b)));
            qstep_nxt    = Q_LUMA_R;
          end
          Q_LUMA_R: begin
            cd_nxt    = acc[12:0];
            mac_op.a  = MAC_A_W'(comp_r);
            mac_op.b  = MAC_B_W'(W_RED);
            qstep_nxt = Q_LUMA_G;
          end
          Q_LUMA_G: begin
            mac_op.accum = 1'b1;
            mac_op.a     = MAC_A_W'(comp_g);
            mac_op.b     = MAC_B_W'(W_GREEN);
            qstep_nxt    = Q_LUMA_B;
          end
          Q_LUMA_B: begin
            mac_op.accum = 1'b1;
            mac_op.a     = MAC_A_W'(comp_b);
            mac_op.b     = MAC_B_W'(W_BLUE);
            qstep_nxt    = Q_LUMA_DIV;
          end
          Q_LUMA_DIV: begin
            mac_op.a  = acc[MAC_A_W-1:0];
            mac_op.b  = MAC_B_W'(GREY_RECIP);
            qstep_nxt = Q_STEP_DIV;
          end
          Q_STEP_DIV: begin
            mac_op.a  = MAC_A_W'(grey_x);
            mac_op.b  = MAC_B_W'(DIV10_MUL);
            qstep_nxt = Q_STEP_TAKE;
          end
          Q_STEP_TAKE: begin
            gi_nxt    = (gi_raw > 5'(GREY_STEP_MAX)) ? 5'(GREY_STEP_MAX) : gi_raw;
            qstep_nxt = Q_GREY_R;
          end
          Q_GREY_R: begin
            mac_op.a  = MAC_A_W'(abs_diff(gv, comp_r));
            mac_op.b  = MAC_B_W'(abs_diff(gv, comp_r));
            qstep_nxt = Q_GREY_G;
          end
          Q_GREY_G: begin
            mac_op.accum = 1'b1;
            mac_op.a     = MAC_A_W'(abs_diff(gv, comp_g));
            mac_op.b     = MAC_B_W'(abs_diff(gv, comp_g));
            qstep_nxt    = Q_GREY_B;
          end
          Q_GREY_B: begin
            mac_op.accum = 1'b1;
            mac_op.a     = MAC_A_W'(abs_diff(gv, comp_b));
            mac_op.b     = MAC_B_W'(abs_diff(gv, comp_b));
            qstep_nxt    = Q_PICK;
          end
          Q_PICK: begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            if (acc[17:0] < 18'(cd_r)) begin
              out_index_nxt = 8'(GREY_FIRST) + 8'(gi_r);
            end else begin
              out_index_nxt = cube_code(ci_r, ci_g, ci_b);
            end
            state_nxt = ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_SCALE: begin
        unique case (sph_r)
          SP_MUL: begin
            mac_op.a      = MAC_A_W'(ch_v);
            mac_op.b      = MAC_B_W'(SCALE_MUL);
            mac_op.addend = MAC_B_W'(SCALE_BIAS);
            sph_nxt       = SP_RECIP;
          end
          SP_RECIP: begin
            mac_op.a = acc[MAC_A_W-1:0];
            mac_op.b = MAC_B_W'(SCALE_RECIP);
            sph_nxt  = SP_TAKE;
          end
          default: begin
            sph_nxt = SP_MUL;
            unique case (ch_r)
              CH_RED: begin
                red_nxt = scaled;
                ch_nxt  = CH_GREEN;
              end
              CH_GREEN: begin
                green_nxt = scaled;
                ch_nxt    = CH_BLUE;
              end
              default: begin
                out_valid_nxt = 1'b1;
                out_wv_nxt    = 1'b1;
                out_slot_nxt  = slot_r;
                out_red_nxt   = red_r;
                out_green_nxt = green_r;
                out_blue_nxt  = scaled;
                if (req_r == REQ_RESTORE) begin
                  out_last_nxt = idx_last;
                  if (idx_last) begin
                    cnt_nxt   = '0;
                    state_nxt = ST_IDLE;
                  end else begin
                    idx_nxt   = idx_inc;
                    state_nxt = ST_RST_RD;
                  end
                end else begin
                  out_index_nxt = slot_r;
                  out_last_nxt  = 1'b1;
                  state_nxt     = ST_IDLE;
                end
              end
            endcase
          end
        endcase
      end

      ST_RST_RD: begin
        state_nxt = ST_RST_LD;
      end

      ST_RST_LD: begin
        slot_nxt  = mem_rdata.index;
        rgb_nxt   = canon_rgb(mem_rdata.index);
        ch_nxt    = CH_RED;
        sph_nxt   = SP_MUL;
        state_nxt = ST_SCALE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      qstep_r     <= Q_CUBE_R;
      sph_r       <= SP_MUL;
      ch_r        <= CH_RED;
      idx_r       <= '0;
      cnt_r       <= '0;
      req_r       <= REQ_MAP;
      exact_r     <= 1'b0;
      tc_r        <= TC_W'(PALETTE_FULL);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qstep_r     <= qstep_nxt;
      sph_r       <= sph_nxt;
      ch_r        <= ch_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      req_r       <= req_nxt;
      exact_r     <= exact_nxt;
      tc_r        <= tc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rgb_r       <= rgb_nxt;
    basic_r     <= basic_nxt;
    slot_r      <= slot_nxt;
    cd_r        <= cd_nxt;
    gi_r        <= gi_nxt;
    red_r       <= red_nxt;
    green_r     <= green_nxt;
    out_index_r <= out_index_nxt;
    out_wv_r    <= out_wv_nxt;
    out_slot_r  <= out_slot_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_color_index = out_index_r;
  assign out_write_valid = out_wv_r;
  assign out_write_slot  = out_slot_r;
  assign out_write_red   = out_red_r;
  assign out_write_green = out_green_r;
  assign out_write_blue  = out_blue_r;
  assign out_last        = out_last_r;

  `ECSA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid_r, "accepted word neither ran nor finished")
  `ECSA_ASSERT_IMPL(a_partial_keeps_busy, out_valid_r && !out_last_r, busy, "non-final result word left the block idle")
  `ECSA_ASSERT_IMPL(a_scan_in_range, state_r == ST_SCAN_CMP, idx_r < cnt_r, "slot scan ran past the allocated slots")
  `ECSA_ASSERT_IMPL(a_restore_clears, out_valid_r && out_last_r && (req_r == REQ_RESTORE), cnt_r == '0, "restore finished with slots still allocated")

endmodule

// ===== sv/ecsa_mac.sv =====
// ----------------------------------------------------------------------------
// Exact color slot allocator multiply-accumulate unit
// Shared 18x19 multiplier with a registered accumulator, one product a cycle.
// ----------------------------------------------------------------------------
module ecsa_mac
  import ecsa_pkg::*;
(
  input  logic             clk,
  input  mac_op_t          op,
  output logic [ACC_W-1:0] acc
);

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] base;

  always_comb begin
    prod    = {{MAC_B_W{1'b0}}, op.a} * {{MAC_A_W{1'b0}}, op.b};
    base    = op.accum ? acc_r : ACC_W'(op.addend);
    acc_nxt = base + prod;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== sv/ecsa_slot_mem.sv =====
// ----------------------------------------------------------------------------
// Exact color slot allocator slot memory
// Holds the color and palette index of each allocated slot, registered read.
// ----------------------------------------------------------------------------
module ecsa_slot_mem
  import ecsa_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_SLOT_COUNT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output slot_entry_t   rdata
);

  slot_entry_t mem_r [DEPTH];
  slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
